FILE: rtl/core/pst_pkg.sv
// Shared types, widths, control codes and the multiply schedule for the
// plane-split tetrahedron volume block.
// No dependencies; every module of the block imports this package.
package pst_pkg;

    // Field and datapath widths
    localparam int COORD_W   = 16;
    localparam int NORM_W    = 16;
    localparam int OFF_W     = 32;
    localparam int ACC_W     = 64;
    localparam int VOL_W     = 63;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int MB_W      = (COORD_W + 2 > NORM_W) ? COORD_W + 2 : NORM_W;
    localparam int PROD_W    = DIFF_W + MB_W;
    localparam int CROSS_W   = 2 * DIFF_W + 1;
    localparam int XL_W      = MB_W - 1;
    localparam int XH_W      = CROSS_W - XL_W;
    localparam int T_W       = 3 * COORD_W + 5;
    localparam int MAG_W     = (T_W > ACC_W + 1) ? T_W : ACC_W + 1;
    localparam int DSUM_W    = ((COORD_W + NORM_W > OFF_W) ? COORD_W + NORM_W : OFF_W) + 4;

    // Divide-by-six unit: one quotient digit of DIV_DIG bits per cycle
    localparam int DIV_DIG   = 4;
    localparam int DIV_STEPS = ACC_W / DIV_DIG;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam logic [3:0] DIVISOR = 4'd6;

    // Multiply schedule: three distance terms, six cross terms, six triple terms
    localparam int N_STEPS = 15;
    localparam int STEP_W  = $clog2(N_STEPS);
    localparam logic [STEP_W-1:0] STEP_DIST_LAST = STEP_W'(2);
    localparam logic [STEP_W-1:0] STEP_LAST      = STEP_W'(N_STEPS - 1);

    // Corner count
    localparam logic [1:0] COUNT_FULL = 2'd3;

    // Configuration port
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam logic [1:0] REG_NX  = 2'd0;
    localparam logic [1:0] REG_NY  = 2'd1;
    localparam logic [1:0] REG_NZ  = 2'd2;
    localparam logic [1:0] REG_OFF = 2'd3;
    localparam logic signed [NORM_W-1:0] NX_RESET  = 16'sd16384;
    localparam logic signed [NORM_W-1:0] NY_RESET  = 16'sd0;
    localparam logic signed [NORM_W-1:0] NZ_RESET  = 16'sd0;
    localparam logic signed [OFF_W-1:0]  OFF_RESET = 32'sd0;

    // Multiplier A operand select
    localparam logic [3:0] A_PX = 4'd0;
    localparam logic [3:0] A_PY = 4'd1;
    localparam logic [3:0] A_PZ = 4'd2;
    localparam logic [3:0] A_U0 = 4'd3;
    localparam logic [3:0] A_U1 = 4'd4;
    localparam logic [3:0] A_U2 = 4'd5;
    localparam logic [3:0] A_V0 = 4'd6;
    localparam logic [3:0] A_V1 = 4'd7;
    localparam logic [3:0] A_V2 = 4'd8;

    // Multiplier B operand select
    localparam logic [3:0] B_NX  = 4'd0;
    localparam logic [3:0] B_NY  = 4'd1;
    localparam logic [3:0] B_NZ  = 4'd2;
    localparam logic [3:0] B_W0  = 4'd3;
    localparam logic [3:0] B_W1  = 4'd4;
    localparam logic [3:0] B_W2  = 4'd5;
    localparam logic [3:0] B_XL0 = 4'd6;
    localparam logic [3:0] B_XL1 = 4'd7;
    localparam logic [3:0] B_XL2 = 4'd8;
    localparam logic [3:0] B_XH0 = 4'd9;
    localparam logic [3:0] B_XH1 = 4'd10;
    localparam logic [3:0] B_XH2 = 4'd11;

    // Where the registered product goes on the following cycle
    localparam logic [2:0] D_NONE = 3'd0;
    localparam logic [2:0] D_DSUM = 3'd1;
    localparam logic [2:0] D_XT   = 3'd2;
    localparam logic [2:0] D_X0   = 3'd3;
    localparam logic [2:0] D_X1   = 3'd4;
    localparam logic [2:0] D_X2   = 3'd5;
    localparam logic [2:0] D_TLO  = 3'd6;
    localparam logic [2:0] D_THI  = 3'd7;

    typedef struct packed {
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
        logic                      set_end;
    } t_in;

    typedef struct packed {
        logic [VOL_W-1:0] front_volume;
        logic [VOL_W-1:0] back_volume;
        logic             partial_dropped;
    } t_out;

    typedef struct packed {
        logic signed [NORM_W-1:0] normal_x;
        logic signed [NORM_W-1:0] normal_y;
        logic signed [NORM_W-1:0] normal_z;
        logic signed [OFF_W-1:0]  plane_offset;
    } t_cfg;

    typedef struct packed {
        logic [3:0] asel;
        logic [3:0] bsel;
        logic [2:0] dest;
    } t_mul_op;

    typedef struct packed {
        logic       load_corner;
        logic       first;
        t_mul_op    mul;
        logic       store_wr;
        logic [1:0] store_idx;
        logic       acc;
        logic       div_step;
        logic       div_first;
        logic       load_out;
        logic       partial;
    } t_dp_cmd;

    // Multiply schedule of one corner (distance) and one tetrahedron (cross, triple)
    function automatic t_mul_op mul_sched(input logic [STEP_W-1:0] step);
        t_mul_op op;
        op = '{asel: A_PX, bsel: B_NX, dest: D_NONE};
        case (step)
            4'd0:    op = '{asel: A_PX, bsel: B_NX,  dest: D_DSUM};
            4'd1:    op = '{asel: A_PY, bsel: B_NY,  dest: D_DSUM};
            4'd2:    op = '{asel: A_PZ, bsel: B_NZ,  dest: D_DSUM};
            4'd3:    op = '{asel: A_V1, bsel: B_W2,  dest: D_XT};
            4'd4:    op = '{asel: A_V2, bsel: B_W1,  dest: D_X0};
            4'd5:    op = '{asel: A_V2, bsel: B_W0,  dest: D_XT};
            4'd6:    op = '{asel: A_V0, bsel: B_W2,  dest: D_X1};
            4'd7:    op = '{asel: A_V0, bsel: B_W1,  dest: D_XT};
            4'd8:    op = '{asel: A_V1, bsel: B_W0,  dest: D_X2};
            4'd9:    op = '{asel: A_U0, bsel: B_XL0, dest: D_TLO};
            4'd10:   op = '{asel: A_U0, bsel: B_XH0, dest: D_THI};
            4'd11:   op = '{asel: A_U1, bsel: B_XL1, dest: D_TLO};
            4'd12:   op = '{asel: A_U1, bsel: B_XH1, dest: D_THI};
            4'd13:   op = '{asel: A_U2, bsel: B_XL2, dest: D_TLO};
            4'd14:   op = '{asel: A_U2, bsel: B_XH2, dest: D_THI};
            default: op = '{asel: A_PX, bsel: B_NX,  dest: D_NONE};
        endcase
        return op;
    endfunction

endpackage

FILE: rtl/core/plane_split_tetra_volume.sv
// Top level of the plane-split tetrahedron volume block.
// Depends on pst_pkg and instantiates pst_regs, pst_ctrl and pst_dp.
//
//   Channel  | Ports                                   | Carries
//   ---------+-----------------------------------------+------------------------------
//   input    | i_in_valid, o_in_stall, i_in_data       | one corner and set_end flag
//   output   | o_out_valid, i_out_stall, o_out_data    | volumes / 6, partial flag
//   config   | psel, penable, pwrite, paddr, pwdata... | normal x/y/z, plane offset
//
// The first three corners of a tetrahedron run the three distance products
// and a store step; the fourth runs the full schedule of 15 products on the
// single shared multiplier, then finishes and accumulates the triple product.
// A set_end corner then runs the divide-by-six and loads the output register;
// the load waits while an earlier result is still stalled.
// Reset is synchronous; the input is stalled during reset and whenever an
// item is in progress. A result waits in its register while the next corner
// is taken.
module plane_split_tetra_volume
    import pst_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in                   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out                  o_out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg    cfg;
    t_dp_cmd cmd;

    // Configuration registers
    pst_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Sequencer
    pst_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_set_end (i_in_data.set_end),
        .i_out_stall  (i_out_stall),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .o_cmd        (cmd)
    );

    // Arithmetic
    pst_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cfg      (cfg),
        .i_cmd      (cmd),
        .o_out_data (o_out_data)
    );

endmodule

FILE: rtl/core/pst_regs.sv
// APB-style register file holding the plane normal and the plane offset.
// Depends on pst_pkg for the register indexes, reset values and t_cfg.
module pst_regs
    import pst_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg       r_cfg;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // Register writes complete in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.normal_x     <= NX_RESET;
            r_cfg.normal_y     <= NY_RESET;
            r_cfg.normal_z     <= NZ_RESET;
            r_cfg.plane_offset <= OFF_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_NX:  r_cfg.normal_x     <= pwdata[NORM_W-1:0];
                REG_NY:  r_cfg.normal_y     <= pwdata[NORM_W-1:0];
                REG_NZ:  r_cfg.normal_z     <= pwdata[NORM_W-1:0];
                REG_OFF: r_cfg.plane_offset <= pwdata[OFF_W-1:0];
            endcase
        end
    end

    // Read data is sign extended to the bus width.
    always_comb begin
        unique case (reg_idx)
            REG_NX:  prdata = CFG_DATA_W'(r_cfg.normal_x);
            REG_NY:  prdata = CFG_DATA_W'(r_cfg.normal_y);
            REG_NZ:  prdata = CFG_DATA_W'(r_cfg.normal_z);
            REG_OFF: prdata = CFG_DATA_W'(r_cfg.plane_offset);
        endcase
    end

endmodule

FILE: rtl/core/pst_dp.sv
// Datapath: corner store, shared multiplier, distance sum, cross and triple
// product, saturating accumulators, divide-by-six unit and output register.
// Depends on pst_pkg; driven cycle by cycle by pst_ctrl through t_dp_cmd.
module pst_dp
    import pst_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_in     i_in_data,
    input  t_cfg    i_cfg,
    input  t_dp_cmd i_cmd,
    output t_out    o_out_data
);

    // Current corner, stored corners, difference vectors, cross product
    logic signed [COORD_W-1:0] r_p [3];
    logic signed [COORD_W-1:0] r_store [3][3];
    logic signed [DIFF_W-1:0]  r_u [3];
    logic signed [DIFF_W-1:0]  r_v [3];
    logic signed [DIFF_W-1:0]  r_w [3];
    logic signed [CROSS_W-1:0] r_xt;
    logic signed [CROSS_W-1:0] r_x [3];

    // Multiplier and product routing
    logic signed [DIFF_W-1:0]  mul_a;
    logic signed [MB_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [PROD_W-1:0]  r_prod;
    logic [2:0]                r_dest;

    // Sums and accumulators
    logic signed [DSUM_W-1:0]  r_dsum;
    logic signed [DSUM_W-1:0]  n_dsum;
    logic signed [T_W-1:0]     r_t;
    logic [T_W-1:0]            t_mag;
    logic [MAG_W-1:0]          mag_ext;
    logic [ACC_W-1:0]          r_vol;
    logic [ACC_W-1:0]          r_pos;
    logic [ACC_W-1:0]          r_neg;
    logic [ACC_W:0]            acc_sum;
    logic [2:0]                r_rem_pos;
    logic [2:0]                r_rem_neg;
    logic [DIV_DIG+2:0]        dig_pos;
    logic [DIV_DIG+2:0]        dig_neg;
    t_out                      r_out;

    // One quotient digit of a division by six; returns {digit, remainder}.
    function automatic logic [DIV_DIG+2:0] div6_digit(input logic [2:0] rem_in,
                                                     input logic [DIV_DIG-1:0] bits);
        logic [3:0]         r;
        logic [DIV_DIG-1:0] q;
        int                 k;
        r = {1'b0, rem_in};
        q = '0;
        for (k = DIV_DIG - 1; k >= 0; k--) begin
            r = {r[2:0], bits[k]};
            if (r >= DIVISOR) begin
                q[k] = 1'b1;
                r    = r - DIVISOR;
            end
        end
        return {q, r[2:0]};
    endfunction

    // Corner capture and store write
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_corner) begin
            r_p[0] <= i_in_data.coord_x;
            r_p[1] <= i_in_data.coord_y;
            r_p[2] <= i_in_data.coord_z;
        end
        if (i_cmd.store_wr) begin
            for (int k = 0; k < 3; k++) begin
                r_store[i_cmd.store_idx][k] <= r_p[k];
            end
        end
    end

    // Edge vectors from the first stored corner
    always_ff @(posedge i_clk) begin
        if (i_cmd.first) begin
            for (int k = 0; k < 3; k++) begin
                r_u[k] <= DIFF_W'(r_store[1][k]) - DIFF_W'(r_store[0][k]);
                r_v[k] <= DIFF_W'(r_store[2][k]) - DIFF_W'(r_store[0][k]);
                r_w[k] <= DIFF_W'(r_p[k]) - DIFF_W'(r_store[0][k]);
            end
        end
    end

    // Operand selection for the shared multiplier
    always_comb begin
        case (i_cmd.mul.asel)
            A_PX:    mul_a = DIFF_W'(r_p[0]);
            A_PY:    mul_a = DIFF_W'(r_p[1]);
            A_PZ:    mul_a = DIFF_W'(r_p[2]);
            A_U0:    mul_a = r_u[0];
            A_U1:    mul_a = r_u[1];
            A_U2:    mul_a = r_u[2];
            A_V0:    mul_a = r_v[0];
            A_V1:    mul_a = r_v[1];
            A_V2:    mul_a = r_v[2];
            default: mul_a = '0;
        endcase
        case (i_cmd.mul.bsel)
            B_NX:    mul_b = MB_W'(i_cfg.normal_x);
            B_NY:    mul_b = MB_W'(i_cfg.normal_y);
            B_NZ:    mul_b = MB_W'(i_cfg.normal_z);
            B_W0:    mul_b = MB_W'(r_w[0]);
            B_W1:    mul_b = MB_W'(r_w[1]);
            B_W2:    mul_b = MB_W'(r_w[2]);
            B_XL0:   mul_b = $signed({1'b0, r_x[0][XL_W-1:0]});
            B_XL1:   mul_b = $signed({1'b0, r_x[1][XL_W-1:0]});
            B_XL2:   mul_b = $signed({1'b0, r_x[2][XL_W-1:0]});
            B_XH0:   mul_b = MB_W'($signed(r_x[0][CROSS_W-1:XL_W]));
            B_XH1:   mul_b = MB_W'($signed(r_x[1][CROSS_W-1:XL_W]));
            B_XH2:   mul_b = MB_W'($signed(r_x[2][CROSS_W-1:XL_W]));
            default: mul_b = '0;
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // The product and its destination tag are registered together.
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        if (!i_rst_n) begin
            r_dest <= D_NONE;
        end else begin
            r_dest <= i_cmd.mul.dest;
        end
    end

    // Cross product: first term parks in r_xt, second term is subtracted.
    always_ff @(posedge i_clk) begin
        case (r_dest)
            D_XT:    r_xt   <= CROSS_W'(r_prod);
            D_X0:    r_x[0] <= r_xt - CROSS_W'(r_prod);
            D_X1:    r_x[1] <= r_xt - CROSS_W'(r_prod);
            D_X2:    r_x[2] <= r_xt - CROSS_W'(r_prod);
            default: ;
        endcase
    end

    // Triple product built from low and high partial products.
    always_ff @(posedge i_clk) begin
        if (i_cmd.first) begin
            r_t <= '0;
        end else begin
            case (r_dest)
                D_TLO:   r_t <= r_t + T_W'(r_prod);
                D_THI:   r_t <= r_t + (T_W'(r_prod) <<< XL_W);
                default: ;
            endcase
        end
    end

    // Magnitude of the triple product, saturated to the accumulator width.
    assign t_mag   = r_t[T_W-1] ? T_W'(-r_t) : T_W'(r_t);
    assign mag_ext = MAG_W'(t_mag);

    always_ff @(posedge i_clk) begin
        r_vol <= (|mag_ext[MAG_W-1:ACC_W]) ? '1 : mag_ext[ACC_W-1:0];
    end

    // Distance sum: plane offset on the first step, products as they arrive.
    always_comb begin
        n_dsum = r_dsum;
        if (r_dest == D_DSUM) begin
            n_dsum = n_dsum + DSUM_W'(r_prod);
        end
        if (i_cmd.first) begin
            n_dsum = n_dsum + DSUM_W'(i_cfg.plane_offset);
        end
        if (i_cmd.acc || i_cmd.load_out) begin
            n_dsum = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dsum <= '0;
        end else begin
            r_dsum <= n_dsum;
        end
    end

    // Saturating accumulate, then in-place division by six for the result.
    assign acc_sum = r_dsum[DSUM_W-1] ? {1'b0, r_neg} + {1'b0, r_vol}
                                      : {1'b0, r_pos} + {1'b0, r_vol};
    assign dig_pos = div6_digit(i_cmd.div_first ? 3'd0 : r_rem_pos,
                                r_pos[ACC_W-1 -: DIV_DIG]);
    assign dig_neg = div6_digit(i_cmd.div_first ? 3'd0 : r_rem_neg,
                                r_neg[ACC_W-1 -: DIV_DIG]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_neg <= '0;
        end else if (i_cmd.load_out) begin
            r_pos <= '0;
            r_neg <= '0;
        end else if (i_cmd.acc) begin
            if (r_dsum[DSUM_W-1]) begin
                r_neg <= acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
            end else begin
                r_pos <= acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
            end
        end else if (i_cmd.div_step) begin
            r_pos <= {r_pos[ACC_W-DIV_DIG-1:0], dig_pos[DIV_DIG+2:3]};
            r_neg <= {r_neg[ACC_W-DIV_DIG-1:0], dig_neg[DIV_DIG+2:3]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_step) begin
            r_rem_pos <= dig_pos[2:0];
            r_rem_neg <= dig_neg[2:0];
        end
    end

    // Output register: quotients are loaded once the division is done.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.front_volume    <= r_pos[VOL_W-1:0];
            r_out.back_volume     <= r_neg[VOL_W-1:0];
            r_out.partial_dropped <= i_cmd.partial;
        end
    end

    assign o_out_data = r_out;

endmodule

FILE: rtl/core/pst_ctrl.sv
// Controller state machine: input handshake, multiply schedule, corner
// counting, division sequencing and output valid.
// Depends on pst_pkg for the schedule, codes and t_dp_cmd.
module pst_ctrl
    import pst_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_set_end,
    input  logic    i_out_stall,
    output logic    o_in_stall,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_STORE = 3'd2;
    localparam logic [2:0] S_TFIN  = 3'd3;
    localparam logic [2:0] S_MAG   = 3'd4;
    localparam logic [2:0] S_ACC   = 3'd5;
    localparam logic [2:0] S_DIV   = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    logic [2:0]           r_state, n_state;
    logic [STEP_W-1:0]    r_step, n_step;
    logic [1:0]           r_count, n_count;
    logic                 r_end, n_end;
    logic [DIV_CNT_W-1:0] r_div, n_div;
    logic                 r_out_valid, n_out_valid;
    logic                 accept;
    logic                 out_blocked;

    assign o_in_stall  = (r_state != S_IDLE) || !i_rst_n;
    assign accept      = i_in_valid && !o_in_stall;
    assign out_blocked = r_out_valid && i_out_stall;
    assign o_out_valid = r_out_valid;

    // Next state and datapath commands
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_count     = r_count;
        n_end       = r_end;
        n_div       = r_div;
        n_out_valid = out_blocked;
        o_cmd       = '0;
        o_cmd.mul   = '{asel: A_PX, bsel: B_NX, dest: D_NONE};
        o_cmd.store_idx = r_count;
        o_cmd.partial   = (r_count != 2'd0);

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load_corner = 1'b1;
                    n_end   = i_in_set_end;
                    n_step  = '0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul   = mul_sched(r_step);
                o_cmd.first = (r_step == '0);
                if (r_step == STEP_DIST_LAST && r_count != COUNT_FULL) begin
                    n_state = S_STORE;
                end else if (r_step == STEP_LAST) begin
                    n_state = S_TFIN;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_STORE: begin
                o_cmd.store_wr = 1'b1;
                n_count = r_count + 1'b1;
                n_div   = '0;
                n_state = r_end ? S_DIV : S_IDLE;
            end
            S_TFIN: begin
                n_state = S_MAG;
            end
            S_MAG: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_count = '0;
                n_div   = '0;
                n_state = r_end ? S_DIV : S_IDLE;
            end
            S_DIV: begin
                o_cmd.div_step  = 1'b1;
                o_cmd.div_first = (r_div == '0);
                if (r_div == DIV_LAST) begin
                    n_state = S_OUT;
                end else begin
                    n_div = r_div + 1'b1;
                end
            end
            S_OUT: begin
                if (!out_blocked) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid = 1'b1;
                    n_count = '0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_count     <= '0;
            r_end       <= 1'b0;
            r_div       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_count     <= n_count;
            r_end       <= n_end;
            r_div       <= n_div;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    // A new result never overwrites one that is still held by a stall.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> !(r_out_valid && i_out_stall))
        else $error("result loaded while the previous one is stalled");

    // A corner is only stored while the tetrahedron is incomplete.
    a_store_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STORE) |-> (r_count != COUNT_FULL))
        else $error("corner store written with four corners held");

    // Accumulating a tetrahedron restarts the corner count.
    a_acc_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |=> (r_count == 2'd0))
        else $error("corner count not cleared after a tetrahedron");

    // The division hands over to the output state after its last digit.
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_div == DIV_LAST) |=> (r_state == S_OUT))
        else $error("division left early or overran");
`endif

endmodule
